@@ hdl/mmu_pkg.sv @@
// Shared types and constants for the matrix multiply unit.
// No dependencies.
`timescale 1ns / 1ps

package mmu_pkg;

	localparam int MAX_DIM = 8;  // largest matrix side, bound by the 3-bit indexes
	localparam int VAL_W = 16;   // Q7.8 element
	localparam int PROD_W = 32;  // Q15.16 single product
	localparam int SUM_W = 35;   // Q18.16 dot-product sum
	localparam int IDX_W = 3;    // row / column field
	localparam int DIM_W = 4;    // size register

	typedef enum logic [1:0] {
		MODE_LOAD_A = 2'd0,
		MODE_LOAD_B = 2'd1,
		MODE_START  = 2'd2
	} mode_t;

	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_ERR
	} state_t;

	// travels with each product through the MAC
	typedef struct packed {
		logic             first;   // first term of a dot product
		logic             last_k;  // final term: sum is complete
		logic             last;    // final element of the run
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} tag_t;

endpackage

@@ hdl/mmu_mac.sv @@
// Shared multiply-accumulate unit: one registered 16x16 multiply, one 35-bit add.
// Depends on mmu_pkg.
`timescale 1ns / 1ps

module mmu_mac
	import mmu_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    valid_s1,
	input  tag_t                    tag_s1,
	input  logic signed [VAL_W-1:0] a_s1,
	input  logic signed [VAL_W-1:0] b_s1,
	output logic                    busy,
	output logic                    done,
	output tag_t                    done_tag,
	output logic signed [SUM_W-1:0] done_value
);

	logic                     valid_s2;
	tag_t                     tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  acc_base;
	logic signed [SUM_W-1:0]  acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= a_s1 * b_s1;
			tag_s2 <= tag_s1;
			if (valid_s2) begin
				acc_q <= acc_next;
			end
		end
	end

	always_comb begin
		acc_base = tag_s2.first ? '0 : acc_q;
		acc_next = acc_base + SUM_W'(prod_s2);
	end

	assign busy = valid_s2;
	assign done = valid_s2 & tag_s2.last_k;
	assign done_tag = tag_s2;
	assign done_value = acc_next;

endmodule

@@ hdl/matrix_multiply_unit.sv @@
// Top level of the matrix multiply unit: element stores, sequencer, APB registers.
// Depends on mmu_pkg and mmu_mac.
`timescale 1ns / 1ps

// Matrix multiply unit. Load requests (mode 0 for A, 1 for B) write one signed
// Q7.8 element into the A or B store at row*MAX_DIM+col; loads outside the
// current sizes and mode 3 are dropped. A start request (mode 2) computes
// C = A x B and returns every element of C in row-major order as a full
// Q18.16 sum, with last set on the final one. If a_cols differs from b_rows
// a single result with dims_error and last set is returned instead.
// Size registers are clamped at use: 0 acts as 1, above MAX_DIM acts as MAX_DIM.
// All products go through one shared multiplier: a start request occupies the
// block for a_rows*b_cols*a_cols store reads (one A and one B read per cycle
// while the pipe is not held), then drains the read/multiply/accumulate pipe,
// and in_ready stays low for that time. Whenever a result sits unclaimed in
// the output register the whole pipe holds. Registers: a_rows at 0x0,
// a_cols at 0x4, b_rows at 0x8, b_cols at 0xC; only write them while idle.

module matrix_multiply_unit
	import mmu_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              mode,
	input  logic [IDX_W-1:0]        elem_row,
	input  logic [IDX_W-1:0]        elem_col,
	input  logic signed [VAL_W-1:0] elem_value,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [IDX_W-1:0]        out_row,
	output logic [IDX_W-1:0]        out_col,
	output logic signed [SUM_W-1:0] out_value,
	output logic                    last,
	output logic                    dims_error,
	// APB register port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = $clog2(DEPTH);
	localparam int IW = $clog2(MAX_DIM);

	// ---------------- configuration registers ----------------
	logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_W'(1);
			a_cols_q <= DIM_W'(1);
			b_rows_q <= DIM_W'(1);
			b_cols_q <= DIM_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_A_ROWS: a_rows_q <= pwdata[DIM_W-1:0];
				REG_A_COLS: a_cols_q <= pwdata[DIM_W-1:0];
				REG_B_ROWS: b_rows_q <= pwdata[DIM_W-1:0];
				REG_B_COLS: b_cols_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_A_ROWS: prdata = 32'(a_rows_q);
			REG_A_COLS: prdata = 32'(a_cols_q);
			REG_B_ROWS: prdata = 32'(b_rows_q);
			REG_B_COLS: prdata = 32'(b_cols_q);
			default:    prdata = '0;
		endcase
	end

	// clamp a size register to 1..MAX_DIM
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] d;
		if (r == '0) begin
			d = DIM_W'(1);
		end else if ({1'b0, r} > (DIM_W + 1)'(MAX_DIM)) begin
			d = DIM_W'(MAX_DIM);
		end else begin
			d = r;
		end
		return d;
	endfunction

	logic [DIM_W-1:0] ar, ac, br, bc;

	assign ar = eff_dim(a_rows_q);
	assign ac = eff_dim(a_cols_q);
	assign br = eff_dim(b_rows_q);
	assign bc = eff_dim(b_cols_q);

	// ---------------- request decode ----------------
	logic   in_acc;
	mode_t  req_mode;
	logic   in_a_range, in_b_range;
	logic   wr_a, wr_b, start;
	logic [AW-1:0] waddr;

	assign in_acc = in_valid & in_ready;
	assign req_mode = mode_t'(mode);
	assign in_a_range = ({1'b0, elem_row} < (IDX_W + 1)'(ar)) &&
			    ({1'b0, elem_col} < (IDX_W + 1)'(ac));
	assign in_b_range = ({1'b0, elem_row} < (IDX_W + 1)'(br)) &&
			    ({1'b0, elem_col} < (IDX_W + 1)'(bc));
	// indexes are below MAX_DIM once range checked, so truncation is safe
	assign waddr = AW'(elem_row) * AW'(MAX_DIM) + AW'(elem_col);

	always_comb begin
		wr_a = 1'b0;
		wr_b = 1'b0;
		start = 1'b0;
		unique case (req_mode)
			MODE_LOAD_A: wr_a = in_acc & in_a_range;
			MODE_LOAD_B: wr_b = in_acc & in_b_range;
			MODE_START:  start = in_acc;
			default: ;
		endcase
	end

	// ---------------- sequencer ----------------
	state_t         state_q, state_d;
	logic [IW-1:0]  i_q, j_q, k_q;
	logic           adv;
	logic           issue;
	logic           k_end, j_end, i_end;
	logic           mac_busy, mac_done;
	tag_t           mac_tag;
	logic signed [SUM_W-1:0] mac_value;
	logic           valid_s1;
	tag_t           tag_s1;

	// pipe moves whenever the output register is free or being emptied
	assign adv = ~out_valid | out_ready;

	assign k_end = (DIM_W'(k_q) == ac - DIM_W'(1));
	assign j_end = (DIM_W'(j_q) == bc - DIM_W'(1));
	assign i_end = (DIM_W'(i_q) == ar - DIM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		issue = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (start) begin
					state_d = (ac != br) ? ST_ERR : ST_RUN;
				end
			end
			ST_RUN: begin
				issue = adv;
				if (adv && k_end && j_end && i_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!valid_s1 && !mac_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (adv) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// i over rows of A, j over columns of B, k over the dot product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (start) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (issue) begin
			if (!k_end) begin
				k_q <= k_q + IW'(1);
			end else begin
				k_q <= '0;
				if (!j_end) begin
					j_q <= j_q + IW'(1);
				end else begin
					j_q <= '0;
					i_q <= i_q + IW'(1);
				end
			end
		end
	end

	// ---------------- element stores ----------------
	logic signed [VAL_W-1:0] a_mem [DEPTH];
	logic signed [VAL_W-1:0] b_mem [DEPTH];
	logic signed [VAL_W-1:0] a_rdata_s1, b_rdata_s1;
	logic [AW-1:0] a_raddr, b_raddr;

	assign a_raddr = AW'(i_q) * AW'(MAX_DIM) + AW'(k_q);
	assign b_raddr = AW'(k_q) * AW'(MAX_DIM) + AW'(j_q);

	always_ff @(posedge clk) begin
		if (wr_a) begin
			a_mem[waddr] <= elem_value;
		end
		if (issue) begin
			a_rdata_s1 <= a_mem[a_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			b_mem[waddr] <= elem_value;
		end
		if (issue) begin
			b_rdata_s1 <= b_mem[b_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tag_s1.first <= (k_q == '0);
			tag_s1.last_k <= k_end;
			tag_s1.last <= k_end & j_end & i_end;
			tag_s1.row <= IDX_W'(i_q);
			tag_s1.col <= IDX_W'(j_q);
		end
	end

	mmu_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.valid_s1   (valid_s1),
		.tag_s1     (tag_s1),
		.a_s1       (a_rdata_s1),
		.b_s1       (b_rdata_s1),
		.busy       (mac_busy),
		.done       (mac_done),
		.done_tag   (mac_tag),
		.done_value (mac_value)
	);

	// ---------------- output register ----------------
	logic load_err;

	assign load_err = (state_q == ST_ERR) & adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= (adv & mac_done) | load_err;
		end
	end

	// error and product loads never coincide
	always_ff @(posedge clk) begin
		if (load_err) begin
			out_row <= '0;
			out_col <= '0;
			out_value <= '0;
			last <= 1'b1;
			dims_error <= 1'b1;
		end else if (adv && mac_done) begin
			out_row <= mac_tag.row;
			out_col <= mac_tag.col;
			out_value <= mac_value;
			last <= mac_tag.last;
			dims_error <= 1'b0;
		end
	end

endmodule
